### hdl/hwd_pkg.sv
// shared types, widths and constants of the 2d haar wavelet stream unit
`timescale 1ns / 1ps

package hwd_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 512;
  localparam int unsigned MAX_HEIGHT_DEF  = 512;
  localparam int unsigned SAMPLE_W        = 11;
  localparam int unsigned LINE_WIDTH_W    = 10;
  localparam int unsigned CFG_DATA_W      = 10;
  localparam int unsigned CFG_INDEX_W     = 1;
  localparam int unsigned BLOCK_IDX_W     = 8;
  localparam int unsigned POS_W           = 2;
  localparam int unsigned SUM_W           = 14;
  localparam int unsigned JOB_QUEUE_DEPTH = 2;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = LINE_WIDTH_W'(512);
  localparam logic signed [SUM_W-1:0] FWD_HI         = SUM_W'(1020);
  localparam logic signed [SUM_W-1:0] FWD_LO         = -SUM_W'(1020);
  localparam logic signed [SUM_W-1:0] PIX_HI         = SUM_W'(255);
  localparam logic signed [SUM_W-1:0] ROUND_HALF     = SUM_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    DIR_FORWARD = 1'b0,
    DIR_INVERSE = 1'b1
  } dir_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DIRECTION  = 1'b0,
    CFG_LINE_WIDTH = 1'b1
  } cfg_reg_e;

  // forward: ll, row detail, column detail, diagonal; inverse: tl, tr, bl, br
  typedef enum logic [POS_W-1:0] {
    POS_LL_TL   = 2'd0,
    POS_ROW_TR  = 2'd1,
    POS_COL_BL  = 2'd2,
    POS_DIAG_BR = 2'd3
  } pos_e;

  typedef struct packed {
    dir_e                    direction;
    logic [LINE_WIDTH_W-1:0] line_width;
  } cfg_t;

  // one finished 2x2 block: a top-left, b top-right, c bottom-left, d bottom-right
  typedef struct packed {
    dir_e                   direction;
    sample_t                a;
    sample_t                b;
    sample_t                c;
    sample_t                d;
    logic [BLOCK_IDX_W-1:0] block_column;
    logic [BLOCK_IDX_W-1:0] block_row;
  } job_t;

endpackage

### hdl/haar_wavelet_2d_stream_unit.sv
// top level of the one-level 2d haar wavelet stream unit
// One-level 2D Haar transform over a raster stream of samples, forward (pixels in,
// doubled coefficients out) or inverse (doubled coefficients in, pixels 0..255 out),
// picked by the direction register; line_width sets the samples per row in use
// (clamped to 2..MAX_WIDTH and made even). Each 2x2 block is finished by its
// bottom-right sample, which yields four results in position order with
// group_last on the fourth; every other sample yields none. The input side takes
// one sample per cycle while the block queue has room; the back end turns each
// block into results at one per cycle while the output register is free or popped.
// The first result reaches the output through the block stage, the job queue and
// the output register. The line store holds whole even rows in two banks (even and
// odd columns) and needs no clearing pass; frame_start restarts the row and column
// counts on the sample that carries it.
// Configuration must be written only while the unit is idle; the unit does not enforce this.
`timescale 1ns / 1ps

module haar_wavelet_2d_stream_unit #(
  parameter int unsigned MAX_WIDTH  = hwd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = hwd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [hwd_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [hwd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample side
  input  logic                                push,
  output logic                                full,
  input  logic                                frame_start_i,
  input  hwd_pkg::sample_t                    sample_value_i,
  // result side
  output logic                                empty,
  input  logic                                pop,
  output hwd_pkg::sample_t                    result_value_o,
  output logic [hwd_pkg::POS_W-1:0]           position_o,
  output logic [hwd_pkg::BLOCK_IDX_W-1:0]     block_column_o,
  output logic [hwd_pkg::BLOCK_IDX_W-1:0]     block_row_o,
  output logic                                group_last_o
);
  import hwd_pkg::*;

  // configuration registers
  dir_e                    direction_q, direction_d;
  logic [LINE_WIDTH_W-1:0] line_width_q, line_width_d;
  cfg_t                    cfg;

  // front to queue, queue to back
  logic job_valid, job_full, q_valid, q_pop;
  job_t front_job, q_job;

  always_comb begin
    direction_d  = direction_q;
    line_width_d = line_width_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_DIRECTION:  direction_d  = dir_e'(cfg_data_i[0]);
        CFG_LINE_WIDTH: line_width_d = cfg_data_i[LINE_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q  <= DIR_FORWARD;
      line_width_q <= LINE_WIDTH_RST;
    end else begin
      direction_q  <= direction_d;
      line_width_q <= line_width_d;
    end
  end

  assign cfg.direction  = direction_q;
  assign cfg.line_width = line_width_q;

  // front: counts position, keeps the even row, assembles each finished block
  hwd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .push_i         (push),
    .full_o         (full),
    .frame_start_i  (frame_start_i),
    .sample_value_i (sample_value_i),
    .job_valid_o    (job_valid),
    .job_o          (front_job),
    .job_full_i     (job_full)
  );

  // decouples sample intake from result delivery
  hwd_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (front_job),
    .full_o  (job_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  // back: four signed sums per block, clamp/round, one result per cycle unless held
  hwd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_job),
    .job_pop_o      (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .result_value_o (result_value_o),
    .position_o     (position_o),
    .block_column_o (block_column_o),
    .block_row_o    (block_row_o),
    .group_last_o   (group_last_o)
  );

  // group_last marks exactly the diagonal / bottom-right result
  a_last_is_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (group_last_o == (position_o == POS_DIAG_BR)))
    else $error("group_last out of step with position");

  // both directions stay inside the doubled-coefficient range
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_value_o >= -11'sd1020 && result_value_o <= 11'sd1020))
    else $error("result value out of range");

  // once a block has started, its next result follows right behind each transaction
  a_group_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !group_last_o) |=>
      (!empty && position_o == $past(position_o) + 2'd1 &&
       block_column_o == $past(block_column_o) && block_row_o == $past(block_row_o)))
    else $error("result group broken up");

endmodule

### hdl/hwd_front.sv
// front end: raster counters, even-row line store and 2x2 block assembly
`timescale 1ns / 1ps

module hwd_front #(
  parameter int unsigned MAX_WIDTH  = hwd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = hwd_pkg::MAX_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hwd_pkg::cfg_t    cfg_i,
  input  logic             push_i,
  output logic             full_o,
  input  logic             frame_start_i,
  input  hwd_pkg::sample_t sample_value_i,
  output logic             job_valid_o,
  output hwd_pkg::job_t    job_o,
  input  logic             job_full_i
);
  import hwd_pkg::*;

  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);
  localparam int unsigned WID_CLOG  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW        = (WID_CLOG > LINE_WIDTH_W) ? WID_CLOG : LINE_WIDTH_W;
  localparam int unsigned MEM_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [COL_W-1:0] col_q, col_d, col_eff;
  logic [ROW_W-1:0] row_q, row_d, row_eff;
  sample_t          prev_q;

  logic [WW-1:0]      lw_ext, w_use, col_nxt;
  logic [ROW_W:0]     row_nxt;
  logic [COL_W+7:0]   col_ext;
  logic [ROW_W+7:0]   row_ext;
  logic [AW-1:0]      addr;
  logic               accept, odd_row, odd_col, is_block;

  // line store split into an even-column and an odd-column bank
  sample_t even_mem [MEM_DEPTH];
  sample_t odd_mem  [MEM_DEPTH];
  sample_t even_rd_q, odd_rd_q;

  logic                   s1_valid_q, s1_valid_d;
  dir_e                   s1_dir_q;
  sample_t                s1_c_q, s1_d_q;
  logic [BLOCK_IDX_W-1:0] s1_bcol_q, s1_brow_q;

  // width in use: clamp to 2..MAX_WIDTH, force even
  always_comb begin
    lw_ext = WW'(cfg_i.line_width);
    if (lw_ext < WW'(2)) begin
      w_use = WW'(2);
    end else if (lw_ext > WW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = lw_ext;
    end
    w_use[0] = 1'b0;
  end

  assign full_o = s1_valid_q & job_full_i;
  assign accept = push_i & ~full_o;

  always_comb begin
    row_eff = frame_start_i ? '0 : row_q;
    if (frame_start_i || (WW'(col_q) >= w_use)) begin
      col_eff = '0;
    end else begin
      col_eff = col_q;
    end
  end

  assign odd_row  = row_eff[0];
  assign odd_col  = col_eff[0];
  assign is_block = odd_row & odd_col;
  assign col_ext  = (COL_W + 8)'(col_eff);
  assign row_ext  = (ROW_W + 8)'(row_eff);
  assign addr     = col_ext[AW:1];

  // advance the raster position
  always_comb begin
    col_nxt = WW'(col_eff) + WW'(1);
    row_nxt = (ROW_W + 1)'(row_eff) + (ROW_W + 1)'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_nxt >= w_use) begin
        col_d = '0;
        if (row_nxt >= (ROW_W + 1)'(MAX_HEIGHT)) begin
          row_d = '0;
        end else begin
          row_d = row_nxt[ROW_W-1:0];
        end
      end else begin
        col_d = col_nxt[COL_W-1:0];
        row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      prev_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        prev_q <= sample_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !odd_row && !odd_col) begin
      even_mem[addr] <= sample_value_i;
    end
    if (accept && !odd_row && odd_col) begin
      odd_mem[addr] <= sample_value_i;
    end
    if (accept && is_block) begin
      even_rd_q <= even_mem[addr];
      odd_rd_q  <= odd_mem[addr];
    end
  end

  // block stage, waits here while the job queue is full
  assign s1_valid_d = accept ? is_block : (s1_valid_q & job_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_block) begin
      s1_dir_q  <= cfg_i.direction;
      s1_c_q    <= prev_q;
      s1_d_q    <= sample_value_i;
      s1_bcol_q <= col_ext[8:1];
      s1_brow_q <= row_ext[8:1];
    end
  end

  assign job_valid_o        = s1_valid_q;
  assign job_o.direction    = s1_dir_q;
  assign job_o.a            = even_rd_q;
  assign job_o.b            = odd_rd_q;
  assign job_o.c            = s1_c_q;
  assign job_o.d            = s1_d_q;
  assign job_o.block_column = s1_bcol_q;
  assign job_o.block_row    = s1_brow_q;

endmodule

### hdl/hwd_job_queue.sv
// short queue of finished blocks between front and back end
`timescale 1ns / 1ps

module hwd_job_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hwd_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hwd_pkg::job_t job_o
);
  import hwd_pkg::*;

  localparam int unsigned PTR_W = $clog2(JOB_QUEUE_DEPTH);

  job_t             entry_q [JOB_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PTR_W + 1)'(JOB_QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign job_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

### hdl/hwd_back.sv
// back end: four results per block, one per cycle while the output register drains
`timescale 1ns / 1ps

module hwd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_valid_i,
  input  hwd_pkg::job_t                       job_i,
  output logic                                job_pop_o,
  output logic                                empty_o,
  input  logic                                pop_i,
  output hwd_pkg::sample_t                    result_value_o,
  output logic [hwd_pkg::POS_W-1:0]           position_o,
  output logic [hwd_pkg::BLOCK_IDX_W-1:0]     block_column_o,
  output logic [hwd_pkg::BLOCK_IDX_W-1:0]     block_row_o,
  output logic                                group_last_o
);
  import hwd_pkg::*;

  logic [POS_W-1:0] k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic             load;

  logic signed [SUM_W-1:0] ta, tb, tc, td, sum, pix, quarter;
  sample_t                 res;

  sample_t                res_q;
  logic [POS_W-1:0]       pos_q;
  logic [BLOCK_IDX_W-1:0] bcol_q, brow_q;
  logic                   last_q;

  assign load      = job_valid_i & (~out_valid_q | pop_i);
  assign job_pop_o = load & (k_q == POS_DIAG_BR);

  // b flips on odd positions, c on the bottom pair, d when exactly one of them flips
  always_comb begin
    ta      = {{(SUM_W - SAMPLE_W){job_i.a[SAMPLE_W-1]}}, job_i.a};
    tb      = {{(SUM_W - SAMPLE_W){job_i.b[SAMPLE_W-1]}}, job_i.b};
    tc      = {{(SUM_W - SAMPLE_W){job_i.c[SAMPLE_W-1]}}, job_i.c};
    td      = {{(SUM_W - SAMPLE_W){job_i.d[SAMPLE_W-1]}}, job_i.d};
    if (k_q[0]) begin
      tb = -tb;
    end
    if (k_q[1]) begin
      tc = -tc;
    end
    if (k_q[0] ^ k_q[1]) begin
      td = -td;
    end
    sum     = ta + tb + tc + td;
    pix     = sum + ROUND_HALF;
    quarter = pix >>> 2;
    if (job_i.direction == DIR_FORWARD) begin
      if (sum > FWD_HI) begin
        res = FWD_HI[SAMPLE_W-1:0];
      end else if (sum < FWD_LO) begin
        res = FWD_LO[SAMPLE_W-1:0];
      end else begin
        res = sum[SAMPLE_W-1:0];
      end
    end else begin
      if (pix < 0) begin
        res = '0;
      end else if (quarter > PIX_HI) begin
        res = PIX_HI[SAMPLE_W-1:0];
      end else begin
        res = quarter[SAMPLE_W-1:0];
      end
    end
  end

  assign k_d         = load ? k_q + POS_W'(1) : k_q;
  assign out_valid_d = load | (out_valid_q & ~pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= res;
      pos_q  <= k_q;
      bcol_q <= job_i.block_column;
      brow_q <= job_i.block_row;
      last_q <= (k_q == POS_DIAG_BR);
    end
  end

  assign empty_o        = ~out_valid_q;
  assign result_value_o = res_q;
  assign position_o     = pos_q;
  assign block_column_o = bcol_q;
  assign block_row_o    = brow_q;
  assign group_last_o   = last_q;

endmodule
